/* src/line_sprite_scan_sorted_core_assert.svh */
// Assertion macros used by the checker file of the sprite scan core.
`ifndef LINE_SPRITE_SCAN_SORTED_CORE_ASSERT_SVH
`define LINE_SPRITE_SCAN_SORTED_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite scan core: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LSS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite scan core: next-cycle check failed");

`endif

/* src/lss_pkg.sv */
package lss_pkg;

    // Default sizes of the table and of the per-line list.
    localparam int TABLE_ENTRIES_DEF = 40;
    localparam int MAX_PER_LINE_DEF  = 10;

    // Fixed field widths and constants.
    localparam int IDX_W      = 6;
    localparam int LINE_BIAS  = 16;
    localparam int H_SHORT    = 8;
    localparam int H_TALL     = 16;

    // Input item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    // Byte lanes of one table entry.
    localparam logic [1:0] LANE_Y     = 2'd0;
    localparam logic [1:0] LANE_X     = 2'd1;
    localparam logic [1:0] LANE_TILE  = 2'd2;
    localparam logic [1:0] LANE_FLAGS = 2'd3;

    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] tile;
        logic [7:0] x;
        logic [7:0] y;
    } sprite_attr_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        sprite_attr_t     attr;
    } pick_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        pick_t    new_pick;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } scan_state_t;

endpackage

/* src/lss_table.sv */
module lss_table #(
    parameter int TABLE_ENTRIES = 40,
    parameter int IW            = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IW-1:0]        wr_entry,
    input  logic [1:0]           wr_lane,
    input  logic [7:0]           wr_byte,
    input  logic                 rd_en,
    input  logic [IW-1:0]        rd_entry,
    output lss_pkg::sprite_attr_t rd_attr
);
    import lss_pkg::*;

    logic [7:0] rd_byte [4];

    // One memory per byte lane; a per-entry valid bit makes unwritten bytes read as zero.
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [7:0] mem [TABLE_ENTRIES];
        logic       vld_reg [TABLE_ENTRIES];
        logic [7:0] rd_reg;
        logic       lane_we;

        assign lane_we = wr_en && (wr_lane == 2'(l));

        // Valid bits are cleared at once by reset.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    vld_reg[i] <= 1'b0;
                end
            end
            else if (lane_we)
            begin
                vld_reg[wr_entry] <= 1'b1;
            end
        end

        // Storage write and registered read.
        always_ff @(posedge clk)
        begin
            if (lane_we)
            begin
                mem[wr_entry] <= wr_byte;
            end
            if (rd_en)
            begin
                rd_reg <= vld_reg[rd_entry] ? mem[rd_entry] : 8'd0;
            end
        end

        assign rd_byte[l] = rd_reg;
    end

    assign rd_attr.y     = rd_byte[LANE_Y];
    assign rd_attr.x     = rd_byte[LANE_X];
    assign rd_attr.tile  = rd_byte[LANE_TILE];
    assign rd_attr.flags = rd_byte[LANE_FLAGS];

endmodule

/* src/lss_cell.sv */
module lss_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lss_pkg::cell_ctrl_t ctrl,
    input  logic               left_keep,
    input  lss_pkg::pick_t     left_pick,
    input  lss_pkg::pick_t     right_pick,
    output logic               keep,
    output lss_pkg::pick_t     pick
);
    import lss_pkg::*;

    pick_t pick_reg;
    pick_t pick_next;

    // A cell keeps its pick on insert when it holds a pick with x not above the new one.
    assign keep = pick_reg.vld && (pick_reg.attr.x <= ctrl.new_pick.attr.x);

    always_comb
    begin
        pick_next = pick_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                pick_next = pick_reg;
            end
            CELL_CLEAR:
            begin
                pick_next.vld = 1'b0;
            end
            CELL_INSERT:
            begin
                // The first cell that does not keep takes the new pick; later cells shift right.
                if (keep)
                begin
                    pick_next = pick_reg;
                end
                else if (left_keep)
                begin
                    pick_next = ctrl.new_pick;
                end
                else
                begin
                    pick_next = left_pick;
                end
            end
            CELL_SHIFT:
            begin
                pick_next = right_pick;
            end
            default:
            begin
                pick_next = pick_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_reg <= '0;
        end
        else
        begin
            pick_reg <= pick_next;
        end
    end

    assign pick = pick_reg;

endmodule

/* src/line_sprite_scan_sorted_core.sv */
// Table write: accepted while idle, no result; the core stays idle and can take another item at once.
// Scan: walks the table, one entry read per cycle from the
// attribute memory, then one result per cycle while out_stall is low (one result if empty).
// No new item is taken until a scan has given its last result.
// Reset clears the table valid bits, the sort chain and tall_reg at once; there is no clearing pass.
module line_sprite_scan_sorted_core
    import lss_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_PER_LINE  = MAX_PER_LINE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] table_offset,
    input  logic [7:0] table_byte,
    input  logic [7:0] scan_line,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] spr_y,
    output logic [7:0] spr_x,
    output logic [7:0] spr_tile,
    output logic [7:0] spr_flags,
    output logic [5:0] entry_index,
    output logic       valid_res,
    output logic       last
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int PW = $clog2(MAX_PER_LINE + 1);

    scan_state_t   state_reg, state_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] eval_idx_reg, eval_idx_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [7:0]    line_reg, line_next;
    logic          tall_reg;

    logic          in_acc, wr_en, rd_en, hit;
    logic [8:0]    target9, y9, span_end9;
    sprite_attr_t  rd_attr;
    cell_ctrl_t    cell_ctrl;
    pick_t         chain_pick [MAX_PER_LINE];
    logic          chain_keep [MAX_PER_LINE];

    assign in_acc  = in_valid && !in_stall;

    // Sprite height register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tall_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            tall_reg <= cfg_wdata;
        end
    end

    // Writes beyond the table are dropped.
    assign wr_en = in_acc && (kind == KIND_WRITE) &&
                   ({1'b0, table_offset} < 9'(TABLE_ENTRIES * 4));

    lss_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IW           (IW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_entry(table_offset[IW+1:2]),
        .wr_lane (table_offset[1:0]),
        .wr_byte (table_byte),
        .rd_en   (rd_en),
        .rd_entry(rd_idx_reg[IW-1:0]),
        .rd_attr (rd_attr)
    );

    // Vertical span test in nine bits so that spans near the bottom do not wrap.
    assign target9   = {1'b0, line_reg} + 9'(LINE_BIAS);
    assign y9        = {1'b0, rd_attr.y};
    assign span_end9 = y9 + (tall_reg ? 9'(H_TALL) : 9'(H_SHORT));
    assign hit       = (y9 <= target9) && (span_end9 > target9) && (rd_attr.x != 8'd0);

    // Scan sequencer: next state, counters and chain control.
    always_comb
    begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        rd_vld_next   = 1'b0;
        eval_idx_next = eval_idx_reg;
        cnt_next      = cnt_reg;
        line_next     = line_reg;
        rd_en         = 1'b0;
        in_stall      = 1'b1;
        out_valid     = 1'b0;

        cell_ctrl.op                = CELL_HOLD;
        cell_ctrl.new_pick.vld      = 1'b1;
        cell_ctrl.new_pick.idx      = IDX_W'(eval_idx_reg);
        cell_ctrl.new_pick.attr     = rd_attr;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && (kind == KIND_SCAN))
                begin
                    line_next    = scan_line;
                    rd_idx_next  = '0;
                    cnt_next     = '0;
                    cell_ctrl.op = CELL_CLEAR;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg < CW'(TABLE_ENTRIES))
                begin
                    rd_en         = 1'b1;
                    rd_vld_next   = 1'b1;
                    eval_idx_next = rd_idx_reg[IW-1:0];
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end
                if (rd_vld_reg && hit && (cnt_reg < PW'(MAX_PER_LINE)))
                begin
                    cell_ctrl.op = CELL_INSERT;
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (rd_vld_reg && (rd_idx_reg == CW'(TABLE_ENTRIES)))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (cnt_reg <= PW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next     = cnt_reg - 1'b1;
                        cell_ctrl.op = CELL_SHIFT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            eval_idx_reg <= '0;
            cnt_reg      <= '0;
            line_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            rd_vld_reg   <= rd_vld_next;
            eval_idx_reg <= eval_idx_next;
            cnt_reg      <= cnt_next;
            line_reg     <= line_next;
        end
    end

    // Sorted chain of cells; cell 0 holds the smallest x and feeds the output.
    for (genvar k = 0; k < MAX_PER_LINE; k++) begin : g_cell
        logic  left_keep;
        pick_t left_pick;
        pick_t right_pick;

        if (k == 0) begin : g_head
            assign left_keep = 1'b1;
            assign left_pick = '0;
        end
        else begin : g_body
            assign left_keep = chain_keep[k-1];
            assign left_pick = chain_pick[k-1];
        end

        if (k == MAX_PER_LINE - 1) begin : g_tail
            assign right_pick = '0;
        end
        else begin : g_mid
            assign right_pick = chain_pick[k+1];
        end

        lss_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .left_keep (left_keep),
            .left_pick (left_pick),
            .right_pick(right_pick),
            .keep      (chain_keep[k]),
            .pick      (chain_pick[k])
        );
    end

    // Result fields; an empty scan shows all zero.
    assign valid_res   = chain_pick[0].vld;
    assign spr_y       = valid_res ? chain_pick[0].attr.y     : 8'd0;
    assign spr_x       = valid_res ? chain_pick[0].attr.x     : 8'd0;
    assign spr_tile    = valid_res ? chain_pick[0].attr.tile  : 8'd0;
    assign spr_flags   = valid_res ? chain_pick[0].attr.flags : 8'd0;
    assign entry_index = valid_res ? chain_pick[0].idx        : 6'd0;
    assign last        = (cnt_reg <= PW'(1));

endmodule

/* src/lss_checker.sv */
module lss_checker #(
    parameter int TABLE_ENTRIES = 40
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] spr_x,
    input logic [5:0] entry_index,
    input logic       valid_res,
    input logic       last
);
    `include "line_sprite_scan_sorted_core_assert.svh"

    // A stalled result holds its valid and its sort key.
    `LSS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(spr_x))

    // No new transaction is taken while results of a scan are pending.
    `LSS_ASSERT_IMP(a_no_in_while_out, out_valid, in_stall)

    // An empty result is always the only and final result of its scan.
    `LSS_ASSERT_IMP(a_empty_is_last, out_valid && !valid_res, last)

    // A picked entry lies inside the table.
    `LSS_ASSERT_IMP(a_index_range, out_valid && valid_res,
                    32'(entry_index) < TABLE_ENTRIES)

    // After the final result is taken, the output goes quiet.
    `LSS_ASSERT_NXT(a_last_ends, out_valid && !out_stall && last, !out_valid)

endmodule

bind line_sprite_scan_sorted_core lss_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
) u_lss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .spr_x      (spr_x),
    .entry_index(entry_index),
    .valid_res  (valid_res),
    .last       (last)
);
